@@ hdl/mm_pkg.sv @@
// Shared types and constants for the matrix multiply block.
`timescale 1ns / 1ps

package mm_pkg;

  localparam int MAX_DIM_DEFAULT = 8;
  localparam int CFG_W           = 4;
  localparam int ELEM_W          = 16;
  localparam int PROD_W          = 2 * ELEM_W;
  localparam int VALUE_W         = 35;
  localparam int IDX_W           = 3;
  // column tag carried along the chain; covers every legal MAX_DIM (up to 16)
  localparam int TOK_COL_W       = 4;

  typedef struct packed {
    logic                     first;
    logic [TOK_COL_W-1:0]     col;
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
  } tok_t;

endpackage

@@ hdl/matrix_multiply.sv @@
// Streaming fixed-point matrix multiply, C = A * B, with a chain of MAC cells.
// Loading: one element per cycle; no stall while loading.
// After the completing transaction, each row of C issues inner*cols products, drains the
// cell chain, then puts out its cols elements (held while the output stalls).
// Input is stalled from the completing transaction until the last element of C is loaded out.
// Reset clears the load counts and sets all dimensions to 8; stores are undefined until written.
`timescale 1ns / 1ps

module matrix_multiply #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [mm_pkg::CFG_W-1:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic signed [mm_pkg::ELEM_W-1:0]  elem_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mm_pkg::IDX_W-1:0]          out_row,
  output logic [mm_pkg::IDX_W-1:0]          out_col,
  output logic signed [mm_pkg::VALUE_W-1:0] out_value,
  output logic                              last
);
  import mm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int COL_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;
  localparam logic       OP_A          = 1'b0;

  typedef enum logic [1:0] {
    S_LOAD,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } state_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(v);
    end
    return d;
  endfunction

  state_t state;

  logic [CFG_W-1:0] rows_a;
  logic [CFG_W-1:0] inner_dim;
  logic [CFG_W-1:0] cols_b;

  logic [DIM_W-1:0] nr;
  logic [DIM_W-1:0] nk;
  logic [DIM_W-1:0] nc;
  logic [CNT_W-1:0] a_size;
  logic [CNT_W-1:0] b_size;

  logic [CNT_W-1:0] a_loaded;
  logic [CNT_W-1:0] b_loaded;
  logic [CNT_W-1:0] a_loaded_next;
  logic [CNT_W-1:0] b_loaded_next;
  logic             a_wr;
  logic             b_wr;
  logic             accept;

  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];
  logic signed [ELEM_W-1:0] a_rd;
  logic signed [ELEM_W-1:0] b_rd;

  logic [ADDR_W-1:0] a_idx;
  logic [ADDR_W-1:0] b_idx;
  logic [DIM_W-1:0]  r;
  logic [DIM_W-1:0]  k;
  logic [DIM_W-1:0]  c;
  logic [DIM_W-1:0]  ec;
  logic [DIM_W-1:0]  drain;

  logic                 meta_valid;
  logic                 meta_first;
  logic [TOK_COL_W-1:0] meta_col;

  logic                        chain_valid [MAX_DIM+1];
  tok_t                        chain_tok   [MAX_DIM+1];
  logic signed [VALUE_W-1:0]   acc_col     [MAX_DIM];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_LOAD);
  assign accept    = in_valid && !in_stall;

  assign nr     = eff_dim(rows_a);
  assign nk     = eff_dim(inner_dim);
  assign nc     = eff_dim(cols_b);
  assign a_size = CNT_W'(nr) * CNT_W'(nk);
  assign b_size = CNT_W'(nk) * CNT_W'(nc);

  always_comb begin
    a_loaded_next = a_loaded;
    b_loaded_next = b_loaded;
    a_wr          = 1'b0;
    b_wr          = 1'b0;
    if (accept) begin
      if (op == OP_A) begin
        if (a_loaded < a_size) begin
          a_wr          = 1'b1;
          a_loaded_next = a_loaded + CNT_W'(1);
        end
      end else begin
        if (b_loaded < b_size) begin
          b_wr          = 1'b1;
          b_loaded_next = b_loaded + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= CFG_W'(8);
      inner_dim <= CFG_W'(8);
      cols_b    <= CFG_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  // element stores, flat row-major, registered read in the cycle after the address is issued
  always_ff @(posedge clk) begin
    if (a_wr) begin
      a_mem[a_loaded[ADDR_W-1:0]] <= elem_value;
    end
    if (b_wr) begin
      b_mem[b_loaded[ADDR_W-1:0]] <= elem_value;
    end
    a_rd <= a_mem[a_idx];
    b_rd <= b_mem[b_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      a_loaded   <= '0;
      b_loaded   <= '0;
      meta_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      meta_valid <= (state == S_RUN);
      meta_first <= (k == '0);
      meta_col   <= TOK_COL_W'(c);
      // S_EMIT handles the output register itself
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          a_loaded <= a_loaded_next;
          b_loaded <= b_loaded_next;
          if (accept && a_loaded_next >= a_size && b_loaded_next >= b_size) begin
            state <= S_RUN;
            r     <= '0;
            k     <= '0;
            c     <= '0;
            a_idx <= '0;
            b_idx <= '0;
          end
        end
        S_RUN: begin
          // one B element per cycle, A element held for a whole row of B
          if (c == nc - DIM_W'(1)) begin
            c     <= '0;
            a_idx <= a_idx + ADDR_W'(1);
            if (k == nk - DIM_W'(1)) begin
              k     <= '0;
              b_idx <= '0;
              drain <= '0;
              state <= S_DRAIN;
            end else begin
              k     <= k + DIM_W'(1);
              b_idx <= b_idx + ADDR_W'(1);
            end
          end else begin
            c     <= c + DIM_W'(1);
            b_idx <= b_idx + ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          // wait until the last used cell has folded in its final product
          if (drain == nc) begin
            ec    <= '0;
            state <= S_EMIT;
          end else begin
            drain <= drain + DIM_W'(1);
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_row   <= IDX_W'(r);
            out_col   <= IDX_W'(ec);
            out_value <= acc_col[ec[COL_W-1:0]];
            last      <= (r == nr - DIM_W'(1)) && (ec == nc - DIM_W'(1));
            if (ec == nc - DIM_W'(1)) begin
              ec <= '0;
              if (r == nr - DIM_W'(1)) begin
                a_loaded <= '0;
                b_loaded <= '0;
                state    <= S_LOAD;
              end else begin
                r     <= r + DIM_W'(1);
                state <= S_RUN;
              end
            end else begin
              ec <= ec + DIM_W'(1);
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign chain_valid[0] = meta_valid;
  assign chain_tok[0]   = '{first: meta_first, col: meta_col, a: a_rd, b: b_rd};

  for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
    mm_cell #(
      .COL(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (chain_valid[i]),
      .in_tok   (chain_tok[i]),
      .fwd_valid(chain_valid[i+1]),
      .fwd_tok  (chain_tok[i+1]),
      .acc      (acc_col[i])
    );
  end

endmodule

@@ hdl/mm_cell.sv @@
// One multiply-accumulate cell of the column chain.
`timescale 1ns / 1ps

module mm_cell #(
  parameter int COL = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  mm_pkg::tok_t                      in_tok,
  output logic                              fwd_valid,
  output mm_pkg::tok_t                      fwd_tok,
  output logic signed [mm_pkg::VALUE_W-1:0] acc
);
  import mm_pkg::*;

  logic                     match;
  logic                     prod_valid;
  logic                     prod_first;
  logic signed [PROD_W-1:0] prod;

  assign match = in_valid && (in_tok.col == TOK_COL_W'(COL));

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid  <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      fwd_valid  <= in_valid;
      prod_valid <= match;
    end
    fwd_tok <= in_tok;
    if (match) begin
      prod       <= $signed(in_tok.a) * $signed(in_tok.b);
      prod_first <= in_tok.first;
    end
    // first term of a row restarts the sum
    if (prod_valid) begin
      acc <= prod_first ? VALUE_W'(prod) : acc + VALUE_W'(prod);
    end
  end

endmodule

@@ sim/tb_matrix_multiply.sv @@
// Self-checking testbench for the streaming fixed-point matrix multiply block.
`timescale 1ns / 1ps

module tb_matrix_multiply;
  import mm_pkg::*;

  localparam int MAX_DIM = 8;
  localparam int STORE_AW = $clog2(MAX_DIM * MAX_DIM);
  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B = 2'd2;
  localparam logic OP_LOAD_A = 1'b0;
  localparam logic OP_LOAD_B = 1'b1;
  localparam int IDLE_PCT = 38;
  localparam int SETTLE_CYCLES = 24;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 250;

  typedef struct {
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } c_elem_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = REG_ROWS_A;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      op = OP_LOAD_A;
  logic signed [ELEM_W-1:0]  elem_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [IDX_W-1:0]          out_row;
  logic [IDX_W-1:0]          out_col;
  logic signed [VALUE_W-1:0] out_value;
  logic                      last;

  logic                      idle_on = 1'b1;
  int                        errors = 0;
  int                        quiet_cycles = 0;

  // shadow copy of the block's state
  logic signed [ELEM_W-1:0]  a_mem [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0]  b_mem [MAX_DIM*MAX_DIM];
  int unsigned               a_count = 0;
  int unsigned               b_count = 0;
  logic [CFG_W-1:0]          dim_cfg [3];
  c_elem_t                   c_expected_q [$];

  matrix_multiply #(.MAX_DIM(MAX_DIM)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .elem_value (elem_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .last       (last)
  );

  always #5 clk = ~clk;

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // Load one element into the shadow stores; emit all of C once both are full.
  task automatic predict_product(input logic sel, input logic signed [ELEM_W-1:0] v);
    int unsigned nr, nk, nc;
    longint acc;
    c_elem_t e;
    nr = eff_dim(dim_cfg[REG_ROWS_A]);
    nk = eff_dim(dim_cfg[REG_INNER_DIM]);
    nc = eff_dim(dim_cfg[REG_COLS_B]);
    if (sel == OP_LOAD_A) begin
      if (a_count < nr * nk) begin
        a_mem[STORE_AW'(a_count)] = v;
        a_count++;
      end
    end else begin
      if (b_count < nk * nc) begin
        b_mem[STORE_AW'(b_count)] = v;
        b_count++;
      end
    end
    if (a_count >= nr * nk && b_count >= nk * nc) begin
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          acc = 0;
          for (int k = 0; k < nk; k++)
            acc += longint'(a_mem[STORE_AW'(r * nk + k)]) *
                   longint'(b_mem[STORE_AW'(k * nc + c)]);
          e.row = IDX_W'(r);
          e.col = IDX_W'(c);
          e.value = acc[VALUE_W-1:0];
          e.last = (r == nr - 1) && (c == nc - 1);
          c_expected_q.push_back(e);
        end
      end
      a_count = 0;
      b_count = 0;
    end
  endtask

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    c_elem_t e;
    if (!rst && out_valid && !out_stall) begin
      if (c_expected_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual row %0d col %0d value %0d",
                 $time, out_row, out_col, out_value);
        errors++;
      end else begin
        e = c_expected_q.pop_front();
        check_field("out_row", 64'(e.row), 64'(out_row));
        check_field("out_col", 64'(e.col), 64'(out_col));
        check_field("out_value", 64'(e.value), 64'(out_value));
        check_field("last", 64'(e.last), 64'(last));
      end
    end
  end

  always @(posedge clk)
    out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               c_expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_elem(input logic sel, input logic signed [ELEM_W-1:0] v);
    int gap;
    gap = 0;
    if (idle_on)
      while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= sel;
    elem_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_product(sel, v);
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle.
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (c_expected_q.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_dims(input logic [CFG_W-1:0] rows, inner, cols);
    logic [CFG_W-1:0] vals [3];
    logic [1:0] idx [3];
    wait_idle(SETTLE_CYCLES);
    vals[0] = rows;
    vals[1] = inner;
    vals[2] = cols;
    idx[0] = REG_ROWS_A;
    idx[1] = REG_INNER_DIM;
    idx[2] = REG_COLS_B;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[2'(i)];
      cfg_data <= vals[2'(i)];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      dim_cfg[idx[2'(i)]] = vals[2'(i)];
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim();
    int p;
    p = $urandom_range(99);
    if (p < 8) return '0;
    if (p < 88) return CFG_W'($urandom_range(4, 1));
    return CFG_W'($urandom_range(15, 5));
  endfunction

  // One full pair of matrices in random interleaved order, with the odd
  // element sent to a matrix that is already full (dropped by the block).
  task automatic send_random_set(input bit hold, output int sent);
    int a_left, b_left, nk;
    bit pick_b;
    nk = eff_dim(dim_cfg[REG_INNER_DIM]);
    a_left = eff_dim(dim_cfg[REG_ROWS_A]) * nk;
    b_left = nk * eff_dim(dim_cfg[REG_COLS_B]);
    sent = 0;
    while (a_left + b_left > 0) begin
      if ((a_left == 0 || b_left == 0) && $urandom_range(9) == 0) begin
        send_elem(a_left == 0 ? OP_LOAD_A : OP_LOAD_B, rand_elem());
      end else begin
        pick_b = (a_left == 0) || (b_left != 0 && $urandom_range(1) == 1);
        send_elem(pick_b ? OP_LOAD_B : OP_LOAD_A, rand_elem());
        if (pick_b) b_left--;
        else a_left--;
        sent++;
      end
    end
    if (hold) wait_idle(0);
  endtask

  task automatic test_corner_values();
    write_dims(4'd1, 4'd1, 4'd1);
    send_elem(OP_LOAD_A, 16'sh8000);
    send_elem(OP_LOAD_B, 16'sh8000);
    send_elem(OP_LOAD_B, 16'sh8000);
    send_elem(OP_LOAD_A, 16'sh7fff);
  endtask

  // a register value of zero acts as one
  task automatic test_zero_dims();
    write_dims(4'd0, 4'd0, 4'd0);
    send_elem(OP_LOAD_B, 16'sh00ff);
    send_elem(OP_LOAD_A, -16'sd1);
  endtask

  // values above the maximum clamp to it; covers row and column 7
  task automatic test_oversize_dims();
    write_dims(4'd15, 4'd1, 4'd9);
    for (int i = 0; i < 8; i++)
      send_elem(OP_LOAD_A, (i % 2) ? 16'sh8000 : 16'sh7fff);
    for (int i = 0; i < 8; i++)
      send_elem(OP_LOAD_B, ELEM_W'((i % 2) ? 16'sh7fff - i : 16'sh8000 + i));
  endtask

  task automatic test_full_drop();
    write_dims(4'd1, 4'd2, 4'd1);
    send_elem(OP_LOAD_A, 16'sh5555);
    send_elem(OP_LOAD_A, 16'shaaaa);
    send_elem(OP_LOAD_A, 16'sh7fff);
    send_elem(OP_LOAD_B, 16'sh1234);
    send_elem(OP_LOAD_B, -16'sd2);
  endtask

  task automatic test_random_sets();
    int set_no, total, n;
    set_no = 0;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      if (set_no == 0) write_dims(4'd8, 4'd8, 4'd8);
      else if ($urandom_range(1) == 1) write_dims(rand_dim(), rand_dim(), rand_dim());
      // sets 3..7 run back to back on both sides
      idle_on <= !(set_no >= 3 && set_no < 8);
      send_random_set(set_no % 4 == 2, n);
      total += n;
      set_no++;
    end
  endtask

  initial begin
    for (int i = 0; i < 3; i++) dim_cfg[2'(i)] = 4'd8;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_values();
    test_zero_dims();
    test_oversize_dims();
    test_full_drop();
    test_random_sets();
    wait_idle(SETTLE_CYCLES);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
